FILE: src/icmp_chk_pkg.sv
// ----------------------------------------------------------------------------
// icmp_chk_pkg
// Shared types and frame offsets for the ICMP echo request checker.
// ----------------------------------------------------------------------------
package icmp_chk_pkg;

  // Frame offsets, counted from the first byte of the Ethernet destination
  localparam int unsigned ETH_TYPE_HI_POS = 12;
  localparam int unsigned ETH_TYPE_LO_POS = 13;
  localparam int unsigned TOT_LEN_HI_POS  = 16;
  localparam int unsigned TOT_LEN_LO_POS  = 17;
  localparam int unsigned ICMP_BASE       = 34;
  localparam int unsigned ECHO_ID_HI_POS  = 38;
  localparam int unsigned ECHO_ID_LO_POS  = 39;
  localparam int unsigned ECHO_SEQ_HI_POS = 40;
  localparam int unsigned ECHO_SEQ_LO_POS = 41;
  localparam int unsigned MIN_FRAME       = 42;

  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  ECHO_REQUEST_TYPE = 8'd8;
  localparam logic [15:0] IPV4_HDR_LEN      = 16'd20;
  localparam logic [15:0] CSUM_GOOD         = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] echo_identifier;
    logic [15:0] echo_sequence;
  } verdict_t;

endpackage

FILE: src/icmp_chk_ifs.sv
// ----------------------------------------------------------------------------
// icmp_chk_ifs
// Valid/ready channels for frame bytes and verdicts.
// ----------------------------------------------------------------------------
interface icmp_chk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icmp_chk_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] echo_identifier;
  logic [15:0] echo_sequence;

  modport source (output valid, output accepted, output echo_identifier,
                  output echo_sequence, input ready);
  modport sink (input valid, input accepted, input echo_identifier,
                input echo_sequence, output ready);
endinterface

FILE: src/icmp_echo_request_checker_unit.sv
// ----------------------------------------------------------------------------
// icmp_echo_request_checker_unit
// Checks an Ethernet frame, one byte per transfer, for a valid ICMP echo
// request and reports identifier and sequence on the final byte.
//
//   channel   dir   payload                                       transfer
//   frame     in    data_byte[7:0], last_byte                     valid & ready
//   verdict   out   accepted, echo_identifier[15:0], echo_sequence[15:0]  valid & ready
//
// One byte per cycle sustained while no final byte stalls; a verdict is formed
// as the final byte leaves the input register and is held in the verdict register.
// Synchronous active-high reset clears counter, header flags and checksum.
// Only a final byte can stall in the input register, and only while an earlier
// verdict is still waiting in the verdict register; meanwhile the input is not
// ready. All other bytes pass through without waiting.
// ----------------------------------------------------------------------------
module icmp_echo_request_checker_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  icmp_chk_in_if.sink    frame,
  icmp_chk_out_if.source verdict
);

  logic                   out_free;
  logic                   beat_valid;
  logic                   fire;
  logic                   res_valid;
  icmp_chk_pkg::beat_t    beat;
  icmp_chk_pkg::verdict_t res;

  icmp_chk_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .out_free   (out_free),
    .beat_valid (beat_valid),
    .beat       (beat),
    .fire       (fire)
  );

  icmp_chk_frame_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  icmp_chk_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .verdict   (verdict),
    .out_free  (out_free)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("verdict register overwritten before transfer");

  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    fire |-> beat_valid)
    else $error("parser advanced on an empty input register");

endmodule

FILE: src/icmp_chk_in_stage.sv
// ----------------------------------------------------------------------------
// icmp_chk_in_stage
// Input register for frame bytes; holds a final byte while the verdict
// register is still occupied.
// ----------------------------------------------------------------------------
module icmp_chk_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  icmp_chk_in_if.sink          frame,
  input  logic                 out_free,
  output logic                 beat_valid,
  output icmp_chk_pkg::beat_t  beat,
  output logic                 fire
);

  // a non-final byte produces no result, so it never waits on the output side
  assign fire        = beat_valid && (!beat.last_byte || out_free);
  assign frame.ready = !beat_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (frame.valid && frame.ready) begin
      beat_valid <= 1'b1;
    end else if (fire) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      beat.data_byte <= frame.data_byte;
      beat.last_byte <= frame.last_byte;
    end
  end

endmodule

FILE: src/icmp_chk_frame_parser.sv
// ----------------------------------------------------------------------------
// icmp_chk_frame_parser
// Per-frame state: byte counter, header tests, running checksum, and the
// verdict formed on the final byte.
// ----------------------------------------------------------------------------
module icmp_chk_frame_parser #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  icmp_chk_pkg::beat_t    beat,
  output logic                   res_valid,
  output icmp_chk_pkg::verdict_t res
);

  // wide enough for the counter and the ICMP length, plus a carry
  localparam int LW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [COUNT_BITS-1:0] POS_MAX = '1;

  logic [COUNT_BITS-1:0] byte_position, byte_position_next;
  logic                  ethertype_ok, ethertype_ok_next;
  logic [7:0]            saved_high_byte, saved_high_byte_next;
  logic [15:0]           ip_total_length, ip_total_length_next;
  logic                  type_ok, type_ok_next;
  logic [15:0]           checksum_sum, checksum_sum_next;
  logic [15:0]           captured_identifier, captured_identifier_next;
  logic [15:0]           captured_sequence, captured_sequence_next;

  logic          counted;
  logic [LW-1:0] pos_ext;
  logic [LW-1:0] icmp_off;
  logic [LW-1:0] icmp_bytes;
  logic          add_en;
  logic [15:0]   word;
  logic [16:0]   sum_raw;
  logic [LW-1:0] frame_bytes;
  logic [LW-1:0] icmp_bytes_final;
  logic          ok;

  always_comb begin
    byte_position_next       = byte_position;
    ethertype_ok_next        = ethertype_ok;
    saved_high_byte_next     = saved_high_byte;
    ip_total_length_next     = ip_total_length;
    type_ok_next             = type_ok;
    captured_identifier_next = captured_identifier;
    captured_sequence_next   = captured_sequence;
    add_en                   = 1'b0;
    word                     = '0;

    counted    = byte_position != POS_MAX;
    pos_ext    = LW'(byte_position);
    icmp_off   = pos_ext - LW'(icmp_chk_pkg::ICMP_BASE);
    icmp_bytes = LW'(ip_total_length) - LW'(icmp_chk_pkg::IPV4_HDR_LEN);

    if (counted) begin
      if (pos_ext == LW'(icmp_chk_pkg::ETH_TYPE_HI_POS)) begin
        saved_high_byte_next = beat.data_byte;
      end else if (pos_ext == LW'(icmp_chk_pkg::ETH_TYPE_LO_POS)) begin
        ethertype_ok_next = {saved_high_byte, beat.data_byte} == icmp_chk_pkg::ETHERTYPE_IPV4;
      end else if (pos_ext == LW'(icmp_chk_pkg::TOT_LEN_HI_POS)) begin
        ip_total_length_next = {beat.data_byte, ip_total_length[7:0]};
      end else if (pos_ext == LW'(icmp_chk_pkg::TOT_LEN_LO_POS)) begin
        ip_total_length_next = {ip_total_length[15:8], beat.data_byte};
      end

      if (pos_ext == LW'(icmp_chk_pkg::ICMP_BASE)) begin
        type_ok_next = beat.data_byte == icmp_chk_pkg::ECHO_REQUEST_TYPE;
      end

      if (pos_ext == LW'(icmp_chk_pkg::ECHO_ID_HI_POS)) begin
        captured_identifier_next = {beat.data_byte, captured_identifier[7:0]};
      end else if (pos_ext == LW'(icmp_chk_pkg::ECHO_ID_LO_POS)) begin
        captured_identifier_next = {captured_identifier[15:8], beat.data_byte};
      end else if (pos_ext == LW'(icmp_chk_pkg::ECHO_SEQ_HI_POS)) begin
        captured_sequence_next = {beat.data_byte, captured_sequence[7:0]};
      end else if (pos_ext == LW'(icmp_chk_pkg::ECHO_SEQ_LO_POS)) begin
        captured_sequence_next = {captured_sequence[15:8], beat.data_byte};
      end

      if (pos_ext >= LW'(icmp_chk_pkg::ICMP_BASE)
          && ip_total_length >= icmp_chk_pkg::IPV4_HDR_LEN
          && icmp_off < icmp_bytes) begin
        if (!icmp_off[0]) begin
          // odd-length tail: pad the lone byte with a zero low byte
          if (icmp_off + LW'(1) == icmp_bytes) begin
            add_en = 1'b1;
            word   = {beat.data_byte, 8'h00};
          end else begin
            saved_high_byte_next = beat.data_byte;
          end
        end else begin
          add_en = 1'b1;
          word   = {saved_high_byte, beat.data_byte};
        end
      end

      byte_position_next = byte_position + COUNT_BITS'(1);
    end

    // one's complement add with end-around carry
    sum_raw           = {1'b0, checksum_sum} + {1'b0, word};
    checksum_sum_next = add_en ? (sum_raw[15:0] + 16'(sum_raw[16])) : checksum_sum;

    frame_bytes      = counted ? (pos_ext + LW'(1)) : LW'(POS_MAX);
    icmp_bytes_final = LW'(ip_total_length_next) - LW'(icmp_chk_pkg::IPV4_HDR_LEN);
    ok = frame_bytes >= LW'(icmp_chk_pkg::MIN_FRAME)
         && ethertype_ok_next && type_ok_next
         && ip_total_length_next >= icmp_chk_pkg::IPV4_HDR_LEN
         && (LW'(icmp_chk_pkg::ICMP_BASE) + icmp_bytes_final) <= frame_bytes
         && checksum_sum_next == icmp_chk_pkg::CSUM_GOOD;

    res_valid           = fire && beat.last_byte;
    res.accepted        = ok;
    res.echo_identifier = ok ? captured_identifier_next : 16'h0000;
    res.echo_sequence   = ok ? captured_sequence_next : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && beat.last_byte)) begin
      byte_position       <= '0;
      ethertype_ok        <= 1'b0;
      saved_high_byte     <= '0;
      ip_total_length     <= '0;
      type_ok             <= 1'b0;
      checksum_sum        <= '0;
      captured_identifier <= '0;
      captured_sequence   <= '0;
    end else if (fire) begin
      byte_position       <= byte_position_next;
      ethertype_ok        <= ethertype_ok_next;
      saved_high_byte     <= saved_high_byte_next;
      ip_total_length     <= ip_total_length_next;
      type_ok             <= type_ok_next;
      checksum_sum        <= checksum_sum_next;
      captured_identifier <= captured_identifier_next;
      captured_sequence   <= captured_sequence_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && beat.last_byte |=> byte_position == '0 && checksum_sum == '0)
    else $error("frame state not cleared after final byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire && !beat.last_byte && byte_position != POS_MAX
      |=> byte_position == $past(byte_position) + COUNT_BITS'(1))
    else $error("byte counter did not advance");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    fire && !beat.last_byte && byte_position == POS_MAX |=> byte_position == POS_MAX)
    else $error("saturated byte counter moved");

  a_accept_needs_csum: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.accepted
      |-> checksum_sum_next == icmp_chk_pkg::CSUM_GOOD
          && ip_total_length_next >= icmp_chk_pkg::IPV4_HDR_LEN)
    else $error("frame accepted without a good checksum");

endmodule

FILE: src/icmp_chk_out_stage.sv
// ----------------------------------------------------------------------------
// icmp_chk_out_stage
// Verdict register driving the result channel.
// ----------------------------------------------------------------------------
module icmp_chk_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  icmp_chk_pkg::verdict_t res,
  icmp_chk_out_if.source         verdict,
  output logic                   out_free
);

  logic                   out_valid;
  icmp_chk_pkg::verdict_t held;

  assign out_free = !out_valid || verdict.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

  assign verdict.valid           = out_valid;
  assign verdict.accepted        = held.accepted;
  assign verdict.echo_identifier = held.echo_identifier;
  assign verdict.echo_sequence   = held.echo_sequence;

endmodule

FILE: tb/icmp_echo_verdict_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icmp_echo_verdict_monitor
// Watches the frame and verdict channels of the ICMP echo request checker.
// It rebuilds the per-frame header and checksum state from every byte
// transfer and checks each verdict, field by field, against the oldest
// outstanding one. Failures and progress counts go back to the top.
// ----------------------------------------------------------------------------
module icmp_echo_verdict_monitor #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  icmp_chk_in_if      frame_mon,
  icmp_chk_out_if     verdict_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned verdict_count,
  output int unsigned accept_count,
  output int unsigned stall_count
);

  localparam logic [COUNT_BITS-1:0] POS_TOP = '1;

  // predicted frame state
  logic [COUNT_BITS-1:0] position;
  logic                  ethertype_seen;
  logic                  echo_type_seen;
  logic [7:0]            pending_high;
  logic [15:0]           total_length;
  logic [16:0]           ones_sum;
  logic [15:0]           frame_identifier;
  logic [15:0]           frame_sequence;

  icmp_chk_pkg::verdict_t expected_verdicts[$];
  int unsigned            err_cnt;
  int unsigned            n_verdicts;
  int unsigned            n_accepts;
  int unsigned            n_stalls;

  function automatic void clear_frame_state();
    position         = '0;
    ethertype_seen   = 1'b0;
    echo_type_seen   = 1'b0;
    pending_high     = '0;
    total_length     = '0;
    ones_sum         = '0;
    frame_identifier = '0;
    frame_sequence   = '0;
  endfunction

  // one's complement add with end-around carry
  function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = acc + {1'b0, word};
    return {1'b0, s[15:0]} + 17'(s[16]);
  endfunction

  function automatic void absorb_frame_byte(input logic [7:0] b, input logic lst);
    longint unsigned        pos;
    longint unsigned        k;
    longint unsigned        icmp_bytes;
    longint unsigned        frame_bytes;
    logic                   counted;
    logic                   ok;
    icmp_chk_pkg::verdict_t v;
    pos     = position;
    counted = (position != POS_TOP);
    if (counted) begin
      case (pos)
        icmp_chk_pkg::ETH_TYPE_HI_POS: pending_high = b;
        icmp_chk_pkg::ETH_TYPE_LO_POS:
          ethertype_seen = ({pending_high, b} == icmp_chk_pkg::ETHERTYPE_IPV4);
        icmp_chk_pkg::TOT_LEN_HI_POS:  total_length[15:8] = b;
        icmp_chk_pkg::TOT_LEN_LO_POS:  total_length[7:0] = b;
        icmp_chk_pkg::ICMP_BASE:
          echo_type_seen = (b == icmp_chk_pkg::ECHO_REQUEST_TYPE);
        icmp_chk_pkg::ECHO_ID_HI_POS:  frame_identifier[15:8] = b;
        icmp_chk_pkg::ECHO_ID_LO_POS:  frame_identifier[7:0] = b;
        icmp_chk_pkg::ECHO_SEQ_HI_POS: frame_sequence[15:8] = b;
        icmp_chk_pkg::ECHO_SEQ_LO_POS: frame_sequence[7:0] = b;
        default: ;
      endcase
      if (pos >= icmp_chk_pkg::ICMP_BASE && total_length >= icmp_chk_pkg::IPV4_HDR_LEN) begin
        k          = pos - icmp_chk_pkg::ICMP_BASE;
        icmp_bytes = longint'(total_length - icmp_chk_pkg::IPV4_HDR_LEN);
        if (k < icmp_bytes) begin
          if (!k[0]) begin
            // odd final byte is padded with a zero low byte
            if (k + 1 == icmp_bytes) ones_sum = ones_add(ones_sum, {b, 8'h00});
            else pending_high = b;
          end else begin
            ones_sum = ones_add(ones_sum, {pending_high, b});
          end
        end
      end
    end
    if (!lst) begin
      if (counted) position = position + 1'b1;
    end else begin
      frame_bytes = counted ? pos + 1 : longint'(POS_TOP);
      ok = frame_bytes >= icmp_chk_pkg::MIN_FRAME && ethertype_seen && echo_type_seen &&
           total_length >= icmp_chk_pkg::IPV4_HDR_LEN;
      if (ok) begin
        icmp_bytes = longint'(total_length - icmp_chk_pkg::IPV4_HDR_LEN);
        ok = (icmp_chk_pkg::ICMP_BASE + icmp_bytes <= frame_bytes) &&
             (ones_sum == {1'b0, icmp_chk_pkg::CSUM_GOOD});
      end
      v.accepted        = ok;
      v.echo_identifier = ok ? frame_identifier : 16'h0000;
      v.echo_sequence   = ok ? frame_sequence : 16'h0000;
      expected_verdicts.push_back(v);
      clear_frame_state();
    end
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : track
    icmp_chk_pkg::verdict_t want;
    if (rst) begin
      clear_frame_state();
      expected_verdicts.delete();
      err_cnt    = 0;
      n_verdicts = 0;
      n_accepts  = 0;
      n_stalls   = 0;
    end else begin
      // input first: a verdict can never belong to a byte taken at the same edge
      if (frame_mon.valid && frame_mon.ready)
        absorb_frame_byte(frame_mon.data_byte, frame_mon.last_byte);
      else if (frame_mon.valid)
        n_stalls++;
      if (verdict_mon.valid && verdict_mon.ready) begin
        n_verdicts++;
        if (verdict_mon.accepted === 1'b1) n_accepts++;
        if (expected_verdicts.size() == 0) begin
          $error("verdict with no frame outstanding: accepted %0b id 0x%0h seq 0x%0h",
                 verdict_mon.accepted, verdict_mon.echo_identifier,
                 verdict_mon.echo_sequence);
          err_cnt++;
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("accepted", 16'(want.accepted), 16'(verdict_mon.accepted));
          compare_field("echo_identifier", want.echo_identifier,
                        verdict_mon.echo_identifier);
          compare_field("echo_sequence", want.echo_sequence, verdict_mon.echo_sequence);
        end
      end
    end
    fail_count    <= err_cnt;
    pending       <= expected_verdicts.size();
    verdict_count <= n_verdicts;
    accept_count  <= n_accepts;
    stall_count   <= n_stalls;
  end

endmodule

FILE: tb/tb_icmp_echo_request_checker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_icmp_echo_request_checker_unit
// Drives Ethernet frames byte by byte into the ICMP echo request checker:
// directed header, length and checksum frames, then mostly well-formed
// echo requests with random content mixed with broken and noise frames.
// Both sides idle at random; the verdict side also holds off once for a
// long stretch. A monitor predicts and compares verdicts.
// ----------------------------------------------------------------------------
module tb_icmp_echo_request_checker_unit;

  // counter width for the block under test
  localparam int          COUNT_BITS        = 11;
  localparam int unsigned CSUM_HI_POS       = 36;
  localparam int unsigned CSUM_LO_POS       = 37;
  localparam int unsigned IDLE_LIMIT        = 2000;
  localparam int unsigned HOLD_AFTER        = 20;
  localparam int unsigned HOLD_CYCLES       = 400;
  localparam int unsigned RANDOM_BYTES      = 1150;
  localparam int unsigned MIN_RANDOM_FRAMES = 20;
  localparam int unsigned CALM_BYTES        = 850;
  localparam int unsigned CALM_FRAMES       = 14;
  localparam int unsigned DRAIN_CYCLES      = 8;
  localparam int          RANDOM_FILL       = -1;

  logic        clk = 1'b0;
  logic        rst;
  logic        calm = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  pkt[$];

  int unsigned fail_count;
  int unsigned pending;
  int unsigned verdict_count;
  int unsigned accept_count;
  int unsigned stall_count;

  icmp_chk_in_if  frame_ch();
  icmp_chk_out_if verdict_ch();

  icmp_echo_request_checker_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_ch),
    .verdict (verdict_ch)
  );

  icmp_echo_verdict_monitor #(
    .COUNT_BITS(COUNT_BITS)
  ) monitor (
    .clk           (clk),
    .rst           (rst),
    .frame_mon     (frame_ch),
    .verdict_mon   (verdict_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .verdict_count (verdict_count),
    .accept_count  (accept_count),
    .stall_count   (stall_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (frame_ch.valid && frame_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // verdict side: short random stalls, plus one long hold-off
  initial begin : verdict_sink
    int unsigned taken;
    int unsigned stall_left;
    logic        held;
    taken      = 0;
    stall_left = 0;
    held       = 1'b0;
    verdict_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (verdict_ch.valid && verdict_ch.ready) taken++;
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        verdict_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        verdict_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        verdict_ch.ready <= (stall_left == 0);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] flip_mask();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void set_total_len(input logic [15:0] len);
    pkt[icmp_chk_pkg::TOT_LEN_HI_POS] = len[15:8];
    pkt[icmp_chk_pkg::TOT_LEN_LO_POS] = len[7:0];
  endfunction

  // well-formed echo request; checksum sealed when the ICMP part is at least four bytes and fits
  function automatic void build_echo(input int unsigned ilen, input int unsigned flen,
                                     input logic [15:0] id, input logic [15:0] seq,
                                     input int fill);
    logic [31:0] acc;
    int unsigned i;
    pkt.delete();
    for (i = 0; i < flen; i++)
      pkt.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    pkt[icmp_chk_pkg::ETH_TYPE_HI_POS] = 8'(icmp_chk_pkg::ETHERTYPE_IPV4 >> 8);
    pkt[icmp_chk_pkg::ETH_TYPE_LO_POS] = 8'(icmp_chk_pkg::ETHERTYPE_IPV4);
    set_total_len(16'(ilen + icmp_chk_pkg::IPV4_HDR_LEN));
    pkt[icmp_chk_pkg::ICMP_BASE]       = icmp_chk_pkg::ECHO_REQUEST_TYPE;
    pkt[icmp_chk_pkg::ECHO_ID_HI_POS]  = id[15:8];
    pkt[icmp_chk_pkg::ECHO_ID_LO_POS]  = id[7:0];
    pkt[icmp_chk_pkg::ECHO_SEQ_HI_POS] = seq[15:8];
    pkt[icmp_chk_pkg::ECHO_SEQ_LO_POS] = seq[7:0];
    if (ilen >= 4 && icmp_chk_pkg::ICMP_BASE + ilen <= flen) begin
      pkt[CSUM_HI_POS] = 8'h00;
      pkt[CSUM_LO_POS] = 8'h00;
      acc = 0;
      for (i = 0; i < ilen; i += 2)
        acc += (i + 1 < ilen)
               ? {pkt[icmp_chk_pkg::ICMP_BASE + i], pkt[icmp_chk_pkg::ICMP_BASE + i + 1]}
               : {pkt[icmp_chk_pkg::ICMP_BASE + i], 8'h00};
      while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
      pkt[CSUM_HI_POS] = ~acc[15:8];
      pkt[CSUM_LO_POS] = ~acc[7:0];
    end
  endfunction

  function automatic void make_random_frame();
    int unsigned fault;
    int unsigned ilen;
    int unsigned flen;
    int unsigned cut;
    int unsigned i;
    ilen = $urandom_range(8, 40);
    flen = icmp_chk_pkg::ICMP_BASE + ilen +
           (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    build_echo(ilen, flen, 16'($urandom), 16'($urandom), RANDOM_FILL);
    fault = $urandom_range(0, 99);
    if (fault < 55) begin
      // left well-formed
    end else if (fault < 61) begin
      pkt[$urandom_range(icmp_chk_pkg::ETH_TYPE_HI_POS,
                         icmp_chk_pkg::ETH_TYPE_LO_POS)] ^= flip_mask();
    end else if (fault < 67) begin
      pkt[icmp_chk_pkg::ICMP_BASE] ^= flip_mask();
    end else if (fault < 75) begin
      pkt[$urandom_range(icmp_chk_pkg::ICMP_BASE,
                         icmp_chk_pkg::ICMP_BASE + ilen - 1)] ^= flip_mask();
    end else if (fault < 80) begin
      set_total_len(16'($urandom_range(0, icmp_chk_pkg::IPV4_HDR_LEN)));
    end else if (fault < 85) begin
      set_total_len(16'(ilen + icmp_chk_pkg::IPV4_HDR_LEN + $urandom_range(1, 8)));
    end else if (fault < 90) begin
      cut = $urandom_range(1, icmp_chk_pkg::MIN_FRAME - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end else begin
      pkt.delete();
      cut = $urandom_range(1, 60);
      for (i = 0; i < cut; i++) pkt.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (!calm && $urandom_range(0, 5) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    frame_ch.valid     <= 1'b1;
    frame_ch.data_byte <= b;
    frame_ch.last_byte <= lst;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int unsigned i;
    for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    frames_sent++;
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned random_frames;
    rst                <= 1'b1;
    frame_ch.valid     <= 1'b0;
    frame_ch.data_byte <= 8'h00;
    frame_ch.last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shortest good request, identifier and sequence at opposite extremes
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'hFFFF, 16'h0000, RANDOM_FILL);
    send_frame();
    // odd ICMP length: last byte padded
    build_echo(9, icmp_chk_pkg::MIN_FRAME + 1, 16'h0000, 16'hFFFF, RANDOM_FILL);
    send_frame();
    // trailing bytes past the ICMP part
    build_echo(12, 50, 16'($urandom), 16'($urandom), RANDOM_FILL);
    send_frame();
    // all-zero and all-one payloads
    build_echo(16, 50, 16'h0000, 16'h0000, 8'h00);
    send_frame();
    build_echo(16, 50, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_frame();
    // ARP ethertype
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'h1234, 16'h5678, RANDOM_FILL);
    pkt[icmp_chk_pkg::ETH_TYPE_LO_POS] = 8'h06;
    send_frame();
    // echo reply instead of request
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'h1234, 16'h5678, RANDOM_FILL);
    pkt[icmp_chk_pkg::ICMP_BASE] = 8'h00;
    send_frame();
    // total length below the IPv4 header, exactly the header, zero, maximum
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'h1111, 16'h2222, RANDOM_FILL);
    set_total_len(icmp_chk_pkg::IPV4_HDR_LEN - 16'd1);
    send_frame();
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'h1111, 16'h2222, RANDOM_FILL);
    set_total_len(icmp_chk_pkg::IPV4_HDR_LEN);
    send_frame();
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'h1111, 16'h2222, RANDOM_FILL);
    set_total_len(16'h0000);
    send_frame();
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'h1111, 16'h2222, RANDOM_FILL);
    set_total_len(16'hFFFF);
    send_frame();
    // ICMP part runs past the end of the frame
    build_echo(20, icmp_chk_pkg::ICMP_BASE + 20, 16'h3333, 16'h4444, RANDOM_FILL);
    while (pkt.size() > icmp_chk_pkg::MIN_FRAME) void'(pkt.pop_back());
    send_frame();
    // bad checksum
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'h5555, 16'h6666, RANDOM_FILL);
    pkt[icmp_chk_pkg::ECHO_SEQ_LO_POS] ^= 8'h01;
    send_frame();
    // one byte short of the minimum frame, then single-byte frames
    build_echo(8, icmp_chk_pkg::MIN_FRAME, 16'h7777, 16'h8888, RANDOM_FILL);
    void'(pkt.pop_back());
    send_frame();
    pkt.delete();
    pkt.push_back(8'hFF);
    send_frame();
    pkt.delete();
    pkt.push_back(8'h00);
    send_frame();

    random_start  = bytes_sent;
    random_frames = 0;
    while (bytes_sent - random_start < RANDOM_BYTES || random_frames < MIN_RANDOM_FRAMES) begin
      if (!calm && bytes_sent - random_start >= CALM_BYTES && random_frames >= CALM_FRAMES)
        calm <= 1'b1;
      make_random_frame();
      send_frame();
      random_frames++;
    end
    frame_ch.valid <= 1'b0;

    // let the monitor take in the last final byte before counting what is left
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d frames in %0d bytes: %0d accepted, %0d rejected",
             frames_sent, bytes_sent, accept_count, verdict_count - accept_count);
    $display("input held off for %0d cycles; verdict side paused once for %0d cycles",
             stall_count, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
